// ===== hw/rtl/hdlf_pkg.sv =====
// hdlf_pkg: shared types, codes and constants of the hex dump line formatter
// no dependencies; imported by hdlf_char_unit, hdlf_seq and hex_dump_line_formatter
package hdlf_pkg;

    // widths fixed by the field definitions
    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 9;
    localparam int CNT_W   = 4;

    // character constants
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] HEX_ALPHA  = 8'h37;
    localparam logic [BYTE_W-1:0] HEX_NUM    = 8'h30;

    // input action codes
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    // configuration register indexes
    localparam logic CFG_PRINTABLE_LOW   = 1'b0;
    localparam logic CFG_PRINTABLE_LIMIT = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEX,
        ST_ASC,
        ST_LF
    } t_state;

    // what the character unit produces this cycle
    typedef enum logic [2:0] {
        K_HEX_HI,
        K_HEX_LO,
        K_SPACE,
        K_ASC,
        K_LF
    } t_kind;

    // control from sequencer to datapath
    typedef struct packed {
        logic  idle;
        logic  emit;
        t_kind kind;
    } t_seq_ctl;

    // uppercase hex digit of a nibble
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] ext;
        ext = {4'h0, nib};
        hex_digit = (nib > 4'd9) ? (ext + HEX_ALPHA) : (ext + HEX_NUM);
    endfunction

endpackage

// ===== hw/rtl/hdlf_char_unit.sv =====
// hdlf_char_unit: shared formatter that turns one held byte into one line character
// depends on hdlf_pkg
module hdlf_char_unit (
    input  hdlf_pkg::t_kind                 i_kind,
    input  logic                            i_held,
    input  logic [hdlf_pkg::BYTE_W-1:0]     i_byte,
    input  logic [hdlf_pkg::BYTE_W-1:0]     i_low,
    input  logic [hdlf_pkg::LIMIT_W-1:0]    i_limit,
    output logic [hdlf_pkg::BYTE_W-1:0]     o_char
);
    import hdlf_pkg::*;

    logic w_dot;

    // outside the printable window
    assign w_dot = (i_byte < i_low) || ({1'b0, i_byte} >= i_limit);

    // character select
    always_comb begin
        case (i_kind)
            K_HEX_HI: o_char = i_held ? hex_digit(i_byte[7:4]) : CHAR_SPACE;
            K_HEX_LO: o_char = i_held ? hex_digit(i_byte[3:0]) : CHAR_SPACE;
            K_SPACE:  o_char = CHAR_SPACE;
            K_ASC:    o_char = !i_held ? CHAR_SPACE : (w_dot ? CHAR_DOT : i_byte);
            K_LF:     o_char = CHAR_LF;
            default:  o_char = CHAR_SPACE;
        endcase
    end

endmodule

// ===== hw/rtl/hdlf_seq.sv =====
// hdlf_seq: line sequencer stepping through hex area, ascii column and line feed
// depends on hdlf_pkg
module hdlf_seq #(
    parameter int BYTES_PER_LINE = 8,
    parameter int IDX_W          = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_adv,
    output hdlf_pkg::t_seq_ctl   o_ctl,
    output logic [IDX_W-1:0]     o_idx
);
    import hdlf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BYTES_PER_LINE - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_sub, n_sub;

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_sub   = r_sub;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_HEX;
                    n_idx   = '0;
                    n_sub   = '0;
                end
            end
            ST_HEX: begin
                if (i_adv) begin
                    if (r_sub == 2'd2) begin
                        n_sub = '0;
                        if (r_idx == LAST_IDX) begin
                            n_state = ST_ASC;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end
            ST_ASC: begin
                if (i_adv) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_LF;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_LF: begin
                if (i_adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl.idle = 1'b0;
        o_ctl.emit = 1'b1;
        o_ctl.kind = K_SPACE;
        case (r_state)
            ST_IDLE: begin
                o_ctl.idle = 1'b1;
                o_ctl.emit = 1'b0;
            end
            ST_HEX: begin
                case (r_sub)
                    2'd0:    o_ctl.kind = K_HEX_HI;
                    2'd1:    o_ctl.kind = K_HEX_LO;
                    default: o_ctl.kind = K_SPACE;
                endcase
            end
            ST_ASC:  o_ctl.kind = K_ASC;
            ST_LF:   o_ctl.kind = K_LF;
            default: o_ctl.emit = 1'b0;
        endcase
    end

    assign o_idx = r_idx;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sub   <= n_sub;
        end
    end

endmodule

// ===== hw/rtl/hex_dump_line_formatter.sv =====
// Hex dump line formatter. Data bytes are gathered into a line of BYTES_PER_LINE entries; when
// the line fills, or on a flush beat while bytes are held, the line goes out one character per
// beat: two uppercase hex digits and a space per byte, an ascii column ('.' outside the window
// printable_low .. printable_limit-1), spaces for unheld positions and a closing line feed
// flagged by o_line_end. After the completing or flushing beat the line goes out one character
// per cycle, while the output is not stalled, through a single shared character unit into the
// output register; input ready stays low until the line feed has entered the output register,
// so also through any output stall. A flush with nothing held emits nothing.
// Depends on hdlf_pkg, hdlf_seq and hdlf_char_unit.
module hex_dump_line_formatter #(
    parameter int BYTES_PER_LINE = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [hdlf_pkg::LIMIT_W-1:0]    i_cfg_wdata,
    // input beats
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic [hdlf_pkg::BYTE_W-1:0]     i_data_byte,
    // output beats
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [hdlf_pkg::BYTE_W-1:0]     o_out_char,
    output logic                            o_line_end
);
    import hdlf_pkg::*;

    localparam int IDX_W = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BYTES_PER_LINE);

    logic [BYTE_W-1:0]  r_low;
    logic [LIMIT_W-1:0] r_limit;
    logic [BYTE_W-1:0]  r_store [0:BYTES_PER_LINE-1];
    logic [CNT_W-1:0]   r_held, n_held;
    logic [CNT_W-1:0]   r_line_cnt;
    logic [BYTE_W-1:0]  r_out_char;
    logic               r_line_end;
    logic               r_out_valid;

    t_seq_ctl           w_ctl;
    logic [IDX_W-1:0]   w_idx;
    logic               w_accept, w_append, w_start, w_adv, w_held;
    logic [CNT_W-1:0]   w_held_inc;
    logic [BYTE_W-1:0]  w_char;

    // input handshake
    assign o_in_ready = w_ctl.idle;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_append   = w_accept && (i_action == ACT_APPEND);
    assign w_held_inc = r_held + 1'b1;
    assign w_start    = (w_append && (w_held_inc == FULL_CNT))
                     || (w_accept && (i_action == ACT_FLUSH) && (r_held != '0));

    // output register frees up when empty or taken
    assign w_adv = !r_out_valid || i_out_ready;

    hdlf_seq #(
        .BYTES_PER_LINE (BYTES_PER_LINE),
        .IDX_W          (IDX_W)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_adv   (w_adv),
        .o_ctl   (w_ctl),
        .o_idx   (w_idx)
    );

    assign w_held = CNT_W'(w_idx) < r_line_cnt;

    hdlf_char_unit u_char (
        .i_kind  (w_ctl.kind),
        .i_held  (w_held),
        .i_byte  (r_store[w_idx]),
        .i_low   (r_low),
        .i_limit (r_limit),
        .o_char  (w_char)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= 8'd32;
            r_limit <= 9'd128;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRINTABLE_LOW:   r_low   <= i_cfg_wdata[BYTE_W-1:0];
                CFG_PRINTABLE_LIMIT: r_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_store[r_held[IDX_W-1:0]] <= i_data_byte;
        end
    end

    // held count
    always_comb begin
        n_held = r_held;
        if (w_start) begin
            n_held = '0;
        end else if (w_append) begin
            n_held = w_held_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_line_cnt <= '0;
        end else begin
            r_held <= n_held;
            if (w_start) begin
                r_line_cnt <= w_append ? w_held_inc : r_held;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.emit && w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit && w_adv) begin
            r_out_char <= w_char;
            r_line_end <= (w_ctl.kind == K_LF);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_line_end  = r_line_end;

    // held count never reaches a full line
    a_held_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held < FULL_CNT)
        else $error("held count reached a full line");

    // nothing is held while a line goes out
    a_empty_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_held == '0))
        else $error("bytes held during emission");

    // a line in flight always has something to show
    a_line_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_line_cnt != '0))
        else $error("empty line emitted");

    // returning to idle follows the line feed beat
    a_ready_after_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_ready) |-> (o_out_valid && o_line_end))
        else $error("ready without line feed");

endmodule
